// File: hdl/icaf_pkg.sv
`default_nettype none

package icaf_pkg;

    // defaults for the top level parameters
    localparam int CORDIC_ITERATIONS_DEF = 16;
    localparam int ANGLE_FRAC_BITS_DEF   = 16;

    // register reset values
    localparam logic [15:0] BLEND_ALPHA_RST = 16'd64225;
    localparam logic [23:0] GYRO_GAIN_RST   = 24'd256140;

    // register index codes
    localparam logic [1:0] REG_BLEND_ALPHA   = 2'd0;
    localparam logic [1:0] REG_GYRO_GAIN     = 2'd1;
    localparam logic [1:0] REG_GYRO_OFFSETS  = 2'd2;
    localparam logic [1:0] REG_ACCEL_OFFSETS = 2'd3;

    // cordic datapath
    localparam int                 CORDIC_XW    = 28;
    localparam int                 CORDIC_ZW    = 32;
    localparam logic signed [17:0] INV_GAIN_Q16 = 18'sd39797;

    // gyro increment: |diff| * gain * dt plus rounding half
    localparam int DVD_W = 58;

    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] gyro_x;
        logic signed [15:0] gyro_y;
        logic signed [15:0] gyro_z;
        logic        [15:0] dt_us;
    } in_beat_t;

    typedef struct packed {
        logic signed [31:0] roll_deg;
        logic signed [31:0] pitch_deg;
        logic signed [31:0] yaw_deg;
    } out_beat_t;

    typedef enum logic [1:0] {
        TOP_IDLE,
        TOP_RUN,
        TOP_MERGE,
        TOP_WAIT
    } top_state_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_ROT,
        PH_MAG,
        PH_ROUND
    } lane_phase_t;

    // arctangent of 2^-i in degrees, q.24
    function automatic logic [29:0] atan_q24(input logic [4:0] idx);
        logic [29:0] v;
        case (idx)
            5'd0:    v = 30'd754974720;
            5'd1:    v = 30'd445687602;
            5'd2:    v = 30'd235489088;
            5'd3:    v = 30'd119537938;
            5'd4:    v = 30'd60000934;
            5'd5:    v = 30'd30029717;
            5'd6:    v = 30'd15018523;
            5'd7:    v = 30'd7509720;
            5'd8:    v = 30'd3754917;
            5'd9:    v = 30'd1877466;
            5'd10:   v = 30'd938734;
            5'd11:   v = 30'd469367;
            5'd12:   v = 30'd234684;
            5'd13:   v = 30'd117342;
            5'd14:   v = 30'd58671;
            5'd15:   v = 30'd29335;
            5'd16:   v = 30'd14668;
            5'd17:   v = 30'd7334;
            5'd18:   v = 30'd3667;
            5'd19:   v = 30'd1833;
            5'd20:   v = 30'd917;
            5'd21:   v = 30'd458;
            5'd22:   v = 30'd229;
            5'd23:   v = 30'd115;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

    // clamp to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        logic signed [31:0] r;
        if (v > 40'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -40'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hdl/icaf_gyro_lane.sv
`default_nettype none

module icaf_gyro_lane #(
    parameter int ANGLE_FRAC_BITS = icaf_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic signed [16:0] diff,
    input  wire logic        [23:0] gain,
    input  wire logic        [15:0] dt,
    output logic                    done,
    output logic signed      [35:0] inc
);

    // divisor is 15625 * 2^PreSh: drop the power of two with a shift, then
    // multiply by a reciprocal of 15625 in four partial products
    localparam int Sh    = 24 - ANGLE_FRAC_BITS;
    localparam int PreSh = 6 + Sh;
    localparam int DvdW  = icaf_pkg::DVD_W;
    localparam logic [DvdW-1:0] HalfDiv = DvdW'(64'd500000 << Sh);
    // ceil(2^62 / 15625), exact for dividends below 2^48
    localparam logic [48:0] Recip   = 49'd295147905179353;
    localparam logic [2:0]  RndCnt  = 3'd1;
    localparam logic [2:0]  LastCnt = 3'd6;

    logic              busy_reg;
    logic              done_reg;
    logic [2:0]        cnt_reg;
    logic              neg_reg;
    logic [16:0]       mag_reg;
    logic [15:0]       dt_reg;
    logic [40:0]       p1_reg;
    logic [47:0]       nrm_reg;
    logic [96:0]       acc_reg;
    logic signed [35:0] inc_reg;

    logic [56:0]       p2;
    logic [DvdW-1:0]   rnd;
    logic [23:0]       a_part;
    logic [24:0]       m_part;
    logic [5:0]        pp_sh;
    logic [48:0]       pp;
    logic [96:0]       pp_wide;
    logic [34:0]       quo;

    always_comb
    begin
        p2  = p1_reg * dt_reg;
        rnd = DvdW'(p2) + HalfDiv;
        case (cnt_reg)
            3'd3:
            begin
                a_part = nrm_reg[23:0];
                m_part = Recip[48:24];
                pp_sh  = 6'd24;
            end
            3'd4:
            begin
                a_part = nrm_reg[47:24];
                m_part = {1'b0, Recip[23:0]};
                pp_sh  = 6'd24;
            end
            3'd5:
            begin
                a_part = nrm_reg[47:24];
                m_part = Recip[48:24];
                pp_sh  = 6'd48;
            end
            default:
            begin
                a_part = nrm_reg[23:0];
                m_part = {1'b0, Recip[23:0]};
                pp_sh  = 6'd0;
            end
        endcase
        pp      = a_part * m_part;
        pp_wide = {48'd0, pp} << pp_sh;
        quo     = acc_reg[96:62];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 3'd1;
            if (cnt_reg == LastCnt)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= diff[16];
            mag_reg <= diff[16] ? 17'(-diff) : 17'(diff);
            dt_reg  <= dt;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == 3'd0)
                p1_reg <= mag_reg * gain;
            else if (cnt_reg == RndCnt)
            begin
                nrm_reg <= 48'(rnd >> PreSh);
                acc_reg <= '0;
            end
            else if (cnt_reg == LastCnt)
                // quotient stays below 2^35
                inc_reg <= neg_reg ? -$signed({1'b0, quo})
                                   :  $signed({1'b0, quo});
            else
                acc_reg <= acc_reg + pp_wide;
        end
    end

    assign done = done_reg;
    assign inc  = inc_reg;

endmodule

`default_nettype wire

// File: hdl/icaf_cordic_lane.sv
`default_nettype none

module icaf_cordic_lane #(
    parameter int CORDIC_ITERATIONS = icaf_pkg::CORDIC_ITERATIONS_DEF,
    parameter int ANGLE_FRAC_BITS   = icaf_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic signed [16:0] num,
    input  wire logic signed [16:0] a,
    input  wire logic signed [16:0] b,
    output logic                    done,
    output logic signed      [31:0] angle
);

    localparam int XW = icaf_pkg::CORDIC_XW;
    localparam int ZW = icaf_pkg::CORDIC_ZW;
    localparam int Sh = 24 - ANGLE_FRAC_BITS;
    localparam logic [4:0] LastIter = 5'(CORDIC_ITERATIONS - 1);
    localparam logic signed [ZW:0] Half = (ZW+1)'(1) <<< (Sh - 1);

    icaf_pkg::lane_phase_t phase_reg, phase_next;
    logic                  pass_reg;
    logic                  done_reg;
    logic [4:0]            iter_reg;
    logic signed [XW-1:0]  x_reg, y_reg;
    logic signed [ZW-1:0]  z_reg;
    logic signed [16:0]    num_reg;
    logic signed [31:0]    angle_reg;

    logic signed [XW-1:0]  dx, dy, x_next, y_next;
    logic signed [ZW-1:0]  at, z_next;
    logic signed [XW+17:0] mag_prod;
    logic signed [ZW:0]    z_round;
    logic        [16:0]    a_abs;

    always_comb
    begin
        dx = x_reg >>> iter_reg;
        dy = y_reg >>> iter_reg;
        at = $signed({2'b00, icaf_pkg::atan_q24(iter_reg)});
        if (!y_reg[XW-1])
        begin
            x_next = x_reg + dy;
            y_next = y_reg - dx;
            z_next = z_reg + at;
        end
        else
        begin
            x_next = x_reg - dy;
            y_next = y_reg + dx;
            z_next = z_reg - at;
        end
        mag_prod = x_reg * icaf_pkg::INV_GAIN_Q16;
        z_round  = (ZW+1)'(z_reg) + Half;
        a_abs    = a[16] ? 17'(-a) : 17'(a);
    end

    // phase sequencing: rotate, magnitude correction, rotate, round
    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            icaf_pkg::PH_IDLE:
                if (start)
                    phase_next = icaf_pkg::PH_ROT;
            icaf_pkg::PH_ROT:
                if (iter_reg == LastIter)
                    phase_next = pass_reg ? icaf_pkg::PH_ROUND : icaf_pkg::PH_MAG;
            icaf_pkg::PH_MAG:
                phase_next = icaf_pkg::PH_ROT;
            icaf_pkg::PH_ROUND:
                phase_next = icaf_pkg::PH_IDLE;
            default:
                phase_next = icaf_pkg::PH_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= icaf_pkg::PH_IDLE;
            done_reg  <= 1'b0;
            pass_reg  <= 1'b0;
            iter_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            if (start)
            begin
                done_reg <= 1'b0;
                pass_reg <= 1'b0;
                iter_reg <= '0;
            end
            else
            begin
                case (phase_reg)
                    icaf_pkg::PH_ROT:
                        iter_reg <= (iter_reg == LastIter) ? 5'd0 : iter_reg + 5'd1;
                    icaf_pkg::PH_MAG:
                        pass_reg <= 1'b1;
                    icaf_pkg::PH_ROUND:
                        done_reg <= 1'b1;
                    default:
                        iter_reg <= iter_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg   <= $signed({3'b000, a_abs, 8'h00});
            y_reg   <= XW'(b) <<< 8;
            z_reg   <= '0;
            num_reg <= num;
        end
        else
        begin
            case (phase_reg)
                icaf_pkg::PH_ROT:
                begin
                    x_reg <= x_next;
                    y_reg <= y_next;
                    z_reg <= z_next;
                end
                icaf_pkg::PH_MAG:
                begin
                    x_reg <= mag_prod[XW+15:16];
                    y_reg <= XW'(num_reg) <<< 8;
                    z_reg <= '0;
                end
                icaf_pkg::PH_ROUND:
                    angle_reg <= 32'(z_round >>> Sh);
                default:
                    x_reg <= x_reg;
            endcase
        end
    end

    assign done  = done_reg;
    assign angle = angle_reg;

endmodule

`default_nettype wire

// File: hdl/icaf_merge.sv
`default_nettype none

module icaf_merge (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic        [15:0] alpha,
    input  wire logic signed [35:0] inc_x,
    input  wire logic signed [35:0] inc_y,
    input  wire logic signed [35:0] inc_z,
    input  wire logic signed [31:0] acc_roll,
    input  wire logic signed [31:0] acc_pitch,
    output logic                    done,
    output icaf_pkg::out_beat_t     angles
);

    logic               busy_reg;
    logic [1:0]         step_reg;
    logic               done_reg;
    logic signed [31:0] roll_reg, pitch_reg, yaw_reg;
    logic signed [31:0] ri_reg, pi_reg;
    logic signed [50:0] m_ri_reg, m_ra_reg, m_pi_reg, m_pa_reg;

    logic signed [17:0] a_s, b_s;
    logic signed [51:0] s_roll, s_pitch;

    always_comb
    begin
        a_s     = $signed({2'b00, alpha});
        b_s     = 18'sd65536 - a_s;
        s_roll  = 52'(m_ri_reg) + 52'(m_ra_reg) + 52'sd32768;
        s_pitch = 52'(m_pi_reg) + 52'(m_pa_reg) + 52'sd32768;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            step_reg  <= '0;
            done_reg  <= 1'b0;
            roll_reg  <= '0;
            pitch_reg <= '0;
            yaw_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 2'd1;
                case (step_reg)
                    2'd0:
                        yaw_reg <= icaf_pkg::sat32(40'(yaw_reg) + 40'(inc_z));
                    2'd2:
                    begin
                        roll_reg  <= icaf_pkg::sat32(40'(s_roll >>> 16));
                        pitch_reg <= icaf_pkg::sat32(40'(s_pitch >>> 16));
                        done_reg  <= 1'b1;
                        busy_reg  <= 1'b0;
                    end
                    default:
                        busy_reg <= 1'b1;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg && step_reg == 2'd0)
        begin
            ri_reg <= icaf_pkg::sat32(40'(roll_reg) + 40'(inc_x));
            pi_reg <= icaf_pkg::sat32(40'(pitch_reg) + 40'(inc_y));
        end
        if (busy_reg && step_reg == 2'd1)
        begin
            m_ri_reg <= 51'(a_s * ri_reg);
            m_ra_reg <= 51'(b_s * acc_roll);
            m_pi_reg <= 51'(a_s * pi_reg);
            m_pa_reg <= 51'(b_s * acc_pitch);
        end
    end

    assign done             = done_reg;
    assign angles.roll_deg  = roll_reg;
    assign angles.pitch_deg = pitch_reg;
    assign angles.yaw_deg   = yaw_reg;

endmodule

`default_nettype wire

// File: hdl/imu_complementary_attitude_filter_top.sv
// channel   direction  handshake              beat
// in        input      in_valid / in_stall    icaf_pkg::in_beat_t (accel, gyro, dt_us)
// out       output     out_valid / out_stall  icaf_pkg::out_beat_t (roll, pitch, yaw)
// cfg       input      cfg_write              cfg_index selects, cfg_data carries value
//
// the two-pass cordic lanes take longer than the gyro lanes and so set the time
// from an accepted beat to out_valid.
// reset clears angles to zero and loads register defaults.
// a new input beat is taken once the merge has handed its result to the
// output register; a stalled output blocks only the next merge.
`default_nettype none

module imu_complementary_attitude_filter_top #(
    parameter int CORDIC_ITERATIONS = icaf_pkg::CORDIC_ITERATIONS_DEF,
    parameter int ANGLE_FRAC_BITS   = icaf_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire icaf_pkg::in_beat_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output icaf_pkg::out_beat_t      out_data,
    input  wire logic                cfg_write,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [47:0]         cfg_data
);

    // configuration registers
    logic [15:0] blend_alpha_reg;
    logic [23:0] gyro_gain_reg;
    logic [47:0] gyro_offsets_reg;
    logic [47:0] accel_offsets_reg;

    icaf_pkg::top_state_t state_reg, state_next;

    logic                out_valid_reg;
    icaf_pkg::out_beat_t out_reg;

    // offset corrected axes, held for the lanes
    logic signed [16:0] ax_reg, ay_reg, az_reg, gx_reg, gy_reg, gz_reg;
    logic [15:0]        dt_reg;
    logic               start_reg;

    logic in_accept;
    logic lanes_done;
    logic merge_start;

    logic gx_done, gy_done, gz_done, roll_done, pitch_done, merge_done;
    logic signed [35:0] inc_x, inc_y, inc_z;
    logic signed [31:0] acc_roll, acc_pitch;
    logic signed [16:0] neg_ax;
    icaf_pkg::out_beat_t merged;

    assign in_accept  = in_valid && !in_stall;
    assign lanes_done = gx_done && gy_done && gz_done && roll_done && pitch_done;
    assign neg_ax     = -ax_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            icaf_pkg::TOP_IDLE:
                if (in_valid)
                    state_next = icaf_pkg::TOP_RUN;
            icaf_pkg::TOP_RUN:
                // lane done flags drop at the start pulse, so skip that cycle
                if (lanes_done && !start_reg)
                    state_next = icaf_pkg::TOP_MERGE;
            icaf_pkg::TOP_MERGE:
                if (!out_valid_reg)
                    state_next = icaf_pkg::TOP_WAIT;
            icaf_pkg::TOP_WAIT:
                if (merge_done)
                    state_next = icaf_pkg::TOP_IDLE;
            default:
                state_next = icaf_pkg::TOP_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        in_stall    = state_reg != icaf_pkg::TOP_IDLE;
        merge_start = state_reg == icaf_pkg::TOP_MERGE && !out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= icaf_pkg::TOP_IDLE;
            start_reg         <= 1'b0;
            out_valid_reg     <= 1'b0;
            blend_alpha_reg   <= icaf_pkg::BLEND_ALPHA_RST;
            gyro_gain_reg     <= icaf_pkg::GYRO_GAIN_RST;
            gyro_offsets_reg  <= '0;
            accel_offsets_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            start_reg <= in_accept;

            // result register: load on merge done, clear when taken
            if (merge_done)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            if (cfg_write)
            begin
                case (cfg_index)
                    icaf_pkg::REG_BLEND_ALPHA:   blend_alpha_reg   <= cfg_data[15:0];
                    icaf_pkg::REG_GYRO_GAIN:     gyro_gain_reg     <= cfg_data[23:0];
                    icaf_pkg::REG_GYRO_OFFSETS:  gyro_offsets_reg  <= cfg_data;
                    icaf_pkg::REG_ACCEL_OFFSETS: accel_offsets_reg <= cfg_data;
                    default:                     gyro_gain_reg     <= gyro_gain_reg;
                endcase
            end
        end
    end

    // offset subtraction at 17 bits, never wraps
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            ax_reg <= 17'(in_data.accel_x) - 17'($signed(accel_offsets_reg[15:0]));
            ay_reg <= 17'(in_data.accel_y) - 17'($signed(accel_offsets_reg[31:16]));
            az_reg <= 17'(in_data.accel_z) - 17'($signed(accel_offsets_reg[47:32]));
            gx_reg <= 17'(in_data.gyro_x) - 17'($signed(gyro_offsets_reg[15:0]));
            gy_reg <= 17'(in_data.gyro_y) - 17'($signed(gyro_offsets_reg[31:16]));
            gz_reg <= 17'(in_data.gyro_z) - 17'($signed(gyro_offsets_reg[47:32]));
            dt_reg <= in_data.dt_us;
        end
        if (merge_done)
            out_reg <= merged;
    end

    // gyro lanes: scaled rate times dt, divided down to the angle format
    icaf_gyro_lane #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_gyro_x (
        .clk(clk), .rst_n(rst_n), .start(start_reg), .diff(gx_reg),
        .gain(gyro_gain_reg), .dt(dt_reg), .done(gx_done), .inc(inc_x)
    );

    icaf_gyro_lane #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_gyro_y (
        .clk(clk), .rst_n(rst_n), .start(start_reg), .diff(gy_reg),
        .gain(gyro_gain_reg), .dt(dt_reg), .done(gy_done), .inc(inc_y)
    );

    icaf_gyro_lane #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_gyro_z (
        .clk(clk), .rst_n(rst_n), .start(start_reg), .diff(gz_reg),
        .gain(gyro_gain_reg), .dt(dt_reg), .done(gz_done), .inc(inc_z)
    );

    // accel lanes: roll = atan2(ay, |(ax,az)|), pitch = atan2(-ax, |(ay,az)|)
    icaf_cordic_lane #(
        .CORDIC_ITERATIONS(CORDIC_ITERATIONS),
        .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
    ) u_cordic_roll (
        .clk(clk), .rst_n(rst_n), .start(start_reg), .num(ay_reg),
        .a(ax_reg), .b(az_reg), .done(roll_done), .angle(acc_roll)
    );

    icaf_cordic_lane #(
        .CORDIC_ITERATIONS(CORDIC_ITERATIONS),
        .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
    ) u_cordic_pitch (
        .clk(clk), .rst_n(rst_n), .start(start_reg), .num(neg_ax),
        .a(ay_reg), .b(az_reg), .done(pitch_done), .angle(acc_pitch)
    );

    // merge: integrate, blend with alpha, holds the angle state
    icaf_merge u_merge (
        .clk(clk), .rst_n(rst_n), .start(merge_start), .alpha(blend_alpha_reg),
        .inc_x(inc_x), .inc_y(inc_y), .inc_z(inc_z),
        .acc_roll(acc_roll), .acc_pitch(acc_pitch),
        .done(merge_done), .angles(merged)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire

// File: verif/imu_complementary_attitude_filter_top_tb.sv
`default_nettype none

module imu_complementary_attitude_filter_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITER_N = icaf_pkg::CORDIC_ITERATIONS_DEF;
    localparam int FRAC_N = icaf_pkg::ANGLE_FRAC_BITS_DEF;
    localparam longint CYCLE_LIMIT = 2000000;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    icaf_pkg::in_beat_t in_data;
    logic out_valid;
    logic out_stall;
    icaf_pkg::out_beat_t out_data;
    logic cfg_write;
    logic [1:0] cfg_index;
    logic [47:0] cfg_data;

    imu_complementary_attitude_filter_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 2 ns clock
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // predictor copy of registers and attitude
    logic [15:0] alpha_q;
    logic [23:0] gain_q;
    logic [47:0] gyro_ofs_q;
    logic [47:0] accel_ofs_q;
    logic signed [31:0] roll_q;
    logic signed [31:0] pitch_q;
    logic signed [31:0] yaw_q;

    icaf_pkg::out_beat_t attitude_q[$];
    int unsigned error_count;
    longint cycle_count;
    bit hold_off;
    bit stall_random;

    // degree arctangent table, q.24
    longint atan_deg[24] = '{
        754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
        15018523, 7509720, 3754917, 1877466, 938734, 469367,
        234684, 117342, 58671, 29335, 14668, 7334,
        3667, 1833, 917, 458, 229, 115
    };

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // rotate (x,y) onto the x axis, accumulating the angle in z
    function automatic void rotate_to_axis(inout longint x, inout longint y, inout longint z);
        longint dx;
        longint dy;
        for (int i = 0; i < ITER_N && i < 24; i++)
        begin
            dx = x >>> i;
            dy = y >>> i;
            if (y >= 0)
            begin
                x += dy;
                y -= dx;
                z += atan_deg[i];
            end
            else
            begin
                x -= dy;
                y += dx;
                z -= atan_deg[i];
            end
        end
    endfunction

    // atan2(num, |(a,b)|), degrees in q.FRAC_N
    function automatic longint tilt_angle(longint num, longint a, longint b);
        longint x;
        longint y;
        longint z;
        x = (a < 0 ? -a : a) * 256;
        y = b * 256;
        z = 0;
        rotate_to_axis(x, y, z);
        x = (x * 39797) >>> 16;
        y = num * 256;
        z = 0;
        rotate_to_axis(x, y, z);
        return (z + (64'sd1 <<< (24 - FRAC_N - 1))) >>> (24 - FRAC_N);
    endfunction

    function automatic longint rate_step(longint diff, logic [15:0] dt);
        logic [63:0] m;
        logic [63:0] dv;
        logic [63:0] q;
        m = 64'(diff < 0 ? -diff : diff) * 64'(gain_q) * 64'(dt);
        dv = 64'd1000000 << (24 - FRAC_N);
        q = (m + dv / 2) / dv;
        return diff < 0 ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint mix_angle(longint integ, longint acc);
        longint a;
        a = longint'(alpha_q);
        return clamp32((a * integ + (65536 - a) * acc + 32768) >>> 16);
    endfunction

    function automatic longint ofs16(logic [47:0] v, int k);
        logic signed [15:0] s;
        s = v[16*k +: 16];
        return longint'(s);
    endfunction

    // advance the predicted attitude by one sample set
    function automatic icaf_pkg::out_beat_t predict_attitude(icaf_pkg::in_beat_t s);
        longint ax;
        longint ay;
        longint az;
        longint gx;
        longint gy;
        longint gz;
        longint acc_r;
        longint acc_p;
        longint r;
        longint p;
        icaf_pkg::out_beat_t o;
        ax = longint'(s.accel_x) - ofs16(accel_ofs_q, 0);
        ay = longint'(s.accel_y) - ofs16(accel_ofs_q, 1);
        az = longint'(s.accel_z) - ofs16(accel_ofs_q, 2);
        gx = longint'(s.gyro_x) - ofs16(gyro_ofs_q, 0);
        gy = longint'(s.gyro_y) - ofs16(gyro_ofs_q, 1);
        gz = longint'(s.gyro_z) - ofs16(gyro_ofs_q, 2);
        acc_r = tilt_angle(ay, ax, az);
        acc_p = tilt_angle(-ax, ay, az);
        r = clamp32(longint'(roll_q) + rate_step(gx, s.dt_us));
        p = clamp32(longint'(pitch_q) + rate_step(gy, s.dt_us));
        yaw_q = 32'(clamp32(longint'(yaw_q) + rate_step(gz, s.dt_us)));
        roll_q = 32'(mix_angle(r, acc_r));
        pitch_q = 32'(mix_angle(p, acc_p));
        o.roll_deg = roll_q;
        o.pitch_deg = pitch_q;
        o.yaw_deg = yaw_q;
        return o;
    endfunction

    function automatic int gap_len();
        int k;
        k = $urandom_range(0, 99);
        if (k < 50)
            return 0;
        if (k < 92)
            return $urandom_range(1, 4);
        return $urandom_range(10, 150);
    endfunction

    // sender: one beat, with optional gap before it; valid stays up after
    // the beat so that a following beat can go back to back
    task automatic send_sample(icaf_pkg::in_beat_t s, bit may_idle);
        int g;
        g = may_idle ? gap_len() : 0;
        if (g != 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= s;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        attitude_q.push_back(predict_attitude(s));
    endtask

    // wait for all results, then let the pipeline drain before a write
    task automatic drain();
        in_valid <= 1'b0;
        while (attitude_q.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [47:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            icaf_pkg::REG_BLEND_ALPHA:   alpha_q = val[15:0];
            icaf_pkg::REG_GYRO_GAIN:     gain_q = val[23:0];
            icaf_pkg::REG_GYRO_OFFSETS:  gyro_ofs_q = val;
            icaf_pkg::REG_ACCEL_OFFSETS: accel_ofs_q = val;
            default:                     ;
        endcase
        @(posedge clk);
    endtask

    function automatic icaf_pkg::in_beat_t rand_sample();
        icaf_pkg::in_beat_t s;
        s = icaf_pkg::in_beat_t'(112'({$urandom, $urandom, $urandom, $urandom}));
        // mostly short dt so angles stay in a realistic range
        if ($urandom_range(0, 3) != 0)
            s.dt_us = 16'($urandom_range(0, 8000));
        return s;
    endfunction

    function automatic icaf_pkg::in_beat_t make_sample(int ax, int ay, int az, int gx,
                                                       int gy, int gz, int dt);
        icaf_pkg::in_beat_t s;
        s.accel_x = 16'(ax);
        s.accel_y = 16'(ay);
        s.accel_z = 16'(az);
        s.gyro_x = 16'(gx);
        s.gyro_y = 16'(gy);
        s.gyro_z = 16'(gz);
        s.dt_us = 16'(dt);
        return s;
    endfunction

    // field extremes, zero dt, all-zero accel, repeated full-scale gyro at defaults
    task automatic test_extremes();
        send_sample(make_sample(0, 0, 0, 0, 0, 0, 0), 1'b0);
        send_sample(make_sample(0, 0, 16384, 100, -100, 50, 4000), 1'b1);
        send_sample(make_sample(32767, 32767, 32767, 32767, 32767, 32767, 65535), 1'b1);
        send_sample(make_sample(-32768, -32768, -32768, -32768, -32768, -32768, 65535),
                    1'b1);
        send_sample(make_sample(-32768, 32767, 0, 12, -7, 3, 0), 1'b1);
        send_sample(make_sample(0, 0, 0, 5000, 5000, 5000, 1000), 1'b1);
        repeat (6)
            send_sample(make_sample(0, 0, -16384, 32767, 32767, 32767, 65535), 1'b1);
        repeat (4)
            send_sample(make_sample(100, -200, 16000, -32768, -32768, -32768, 65535), 1'b1);
        drain();
    endtask

    // alpha zero, alpha max, extreme gain and offsets
    task automatic test_register_extremes();
        write_reg(icaf_pkg::REG_BLEND_ALPHA, 48'd0);
        send_sample(make_sample(1000, -2000, 15000, 10, 10, 10, 4000), 1'b0);
        send_sample(make_sample(0, 0, 0, 0, 0, 0, 0), 1'b1);
        drain();
        write_reg(icaf_pkg::REG_BLEND_ALPHA, 48'hffff);
        write_reg(icaf_pkg::REG_GYRO_GAIN, 48'hffffff);
        write_reg(icaf_pkg::REG_GYRO_OFFSETS, 48'h8000_7fff_8000);
        write_reg(icaf_pkg::REG_ACCEL_OFFSETS, 48'h7fff_8000_7fff);
        send_sample(make_sample(-32768, 32767, -32768, 32767, -32768, 32767, 65535), 1'b0);
        send_sample(make_sample(32767, -32768, 32767, -32768, 32767, -32768, 65535), 1'b1);
        drain();
        write_reg(icaf_pkg::REG_GYRO_GAIN, 48'd0);
        send_sample(make_sample(500, 500, 500, 32767, 32767, 32767, 65535), 1'b0);
        drain();
    endtask

    // random settings per phase, random beats with gaps
    task automatic test_random(int phases, int per_phase);
        for (int ph = 0; ph < phases; ph++)
        begin
            write_reg(icaf_pkg::REG_BLEND_ALPHA,
                      48'($urandom_range(0, 3) == 0 ? $urandom
                                                    : $urandom_range(60000, 65535)));
            write_reg(icaf_pkg::REG_GYRO_GAIN,
                      48'($urandom_range(0, 2) == 0 ? $urandom
                                                    : $urandom_range(0, 600000)));
            write_reg(icaf_pkg::REG_GYRO_OFFSETS, 48'({$urandom, $urandom}));
            write_reg(icaf_pkg::REG_ACCEL_OFFSETS,
                      ($urandom_range(0, 1) == 0) ? 48'd0 : 48'({$urandom, $urandom}));
            for (int n = 0; n < per_phase; n++)
                send_sample(rand_sample(), 1'b1);
            drain();
        end
    endtask

    // receiver holds off while the sender keeps offering beats
    task automatic test_backpressure();
        hold_off = 1'b1;
        fork
            begin
                repeat (600) @(posedge clk);
                hold_off = 1'b0;
            end
            begin
                for (int n = 0; n < 20; n++)
                    send_sample(rand_sample(), 1'b0);
            end
        join
        drain();
    endtask

    // stall driver: random gaps with calm stretches
    initial
    begin
        int g;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
                out_stall <= 1'b1;
            else if (!stall_random)
                out_stall <= 1'b0;
            else
            begin
                g = gap_len();
                if (g != 0)
                begin
                    out_stall <= 1'b1;
                    repeat (g - 1) @(posedge clk);
                    if (!hold_off)
                    begin
                        @(posedge clk);
                        out_stall <= 1'b0;
                    end
                end
                else
                    out_stall <= 1'b0;
            end
        end
    end

    // toggle between calm and stalled stretches
    initial
    begin
        stall_random = 1'b0;
        forever
        begin
            repeat ($urandom_range(200, 3000)) @(posedge clk);
            stall_random = ~stall_random;
        end
    end

    // result checker
    always @(posedge clk)
    begin
        icaf_pkg::out_beat_t exp_b;
        if (rst_n && out_valid && !out_stall)
        begin
            if (attitude_q.size() == 0)
            begin
                $error("unexpected result beat");
                error_count++;
            end
            else
            begin
                exp_b = attitude_q.pop_front();
                if (out_data.roll_deg !== exp_b.roll_deg)
                begin
                    $error("roll_deg expected %0d actual %0d", exp_b.roll_deg,
                           out_data.roll_deg);
                    error_count++;
                end
                if (out_data.pitch_deg !== exp_b.pitch_deg)
                begin
                    $error("pitch_deg expected %0d actual %0d", exp_b.pitch_deg,
                           out_data.pitch_deg);
                    error_count++;
                end
                if (out_data.yaw_deg !== exp_b.yaw_deg)
                begin
                    $error("yaw_deg expected %0d actual %0d", exp_b.yaw_deg,
                           out_data.yaw_deg);
                    error_count++;
                end
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        error_count = 0;
        cycle_count = 0;
        hold_off = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_write = 1'b0;
        cfg_index = icaf_pkg::REG_BLEND_ALPHA;
        cfg_data = '0;
        alpha_q = icaf_pkg::BLEND_ALPHA_RST;
        gain_q = icaf_pkg::GYRO_GAIN_RST;
        gyro_ofs_q = '0;
        accel_ofs_q = '0;
        roll_q = '0;
        pitch_q = '0;
        yaw_q = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        test_register_extremes();
        test_backpressure();
        test_random(10, 185);
        drain();
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
